>>> src/dlrs_pkg.sv
// Shared types, codes and constants of the device loss recovery sequencer.
`default_nettype none

package dlrs_pkg;

  // Field widths fixed by the channel definitions
  localparam int KIND_W     = 4;
  localparam int EPOCH_W    = 32;
  localparam int BOUND_W    = 4;
  localparam int CODE_W     = 32;
  localparam int NOW_W      = 48;
  localparam int SEL_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 4;
  localparam int CNT_OUT_W  = 32;
  localparam int BACKOFF_W  = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_COUNTERS = 9;

  // Defaults for the top-level parameters
  localparam int DEF_COUNTER_WIDTH = 32;
  localparam int DEF_TIME_WIDTH    = 48;

  // Register values after reset
  localparam logic [EPOCH_W-1:0]   RST_INITIAL_EPOCH   = 32'd1;
  localparam logic [BACKOFF_W-1:0] RST_INITIAL_BACKOFF = 22'd1000;
  localparam logic [BACKOFF_W-1:0] RST_MAX_BACKOFF     = 22'd60000;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    M_HW       = 4'd0,
    M_LOSS     = 4'd1,
    M_QUIESCE  = 4'd2,
    M_RECREATE = 4'd3,
    M_FBCREATE = 4'd4,
    M_FBREADY  = 4'd5,
    M_SW       = 4'd6,
    M_PROBE    = 4'd7,
    M_CLOSED   = 4'd8
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_CLOSED  = 2'd1,
    ST_STALE   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOSS           = 4'd0,
    KIND_QUIESCE        = 4'd1,
    KIND_RECREATE_START = 4'd2,
    KIND_RECREATE_DONE  = 4'd3,
    KIND_FALLBACK_DONE  = 4'd4,
    KIND_PROBE_START    = 4'd5,
    KIND_PROBE_DONE     = 4'd6,
    KIND_CLOSE          = 4'd7,
    KIND_QUERY          = 4'd8
  } kind_t;

  typedef enum logic [SEL_W-1:0] {
    CNT_LOSS      = 4'd0,
    CNT_STALE     = 4'd1,
    CNT_DUP_LOSS  = 4'd2,
    CNT_HW_TRY    = 4'd3,
    CNT_HW_OK     = 4'd4,
    CNT_FB_TRY    = 4'd5,
    CNT_FB_OK     = 4'd6,
    CNT_SW        = 4'd7,
    CNT_PROBE_TRY = 4'd8
  } cnt_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_EPOCH   = 2'd0,
    CFG_INITIAL_BACKOFF = 2'd1,
    CFG_MAX_BACKOFF     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [EPOCH_W-1:0]  observed_epoch;
    logic [BOUND_W-1:0]  failure_boundary;
    logic [CODE_W-1:0]   failure_code;
    logic                succeeded;
    logic [NOW_W-1:0]    now_ms;
    logic [SEL_W-1:0]    counter_select;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [MODE_W-1:0]    device_state;
    logic [EPOCH_W-1:0]   epoch_now;
    logic                 submission_allowed;
    logic [BOUND_W-1:0]   last_boundary;
    logic [CODE_W-1:0]    last_code;
    logic [CNT_OUT_W-1:0] counter_value;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic     en;
    cnt_sel_t idx;
  } bump_t;

endpackage

`default_nettype wire

>>> src/dlrs_ifs.sv
// Valid/ready channel interfaces: event input, result output and register writes.
`default_nettype none

interface dlrs_in_if
  import dlrs_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [EPOCH_W-1:0]        observed_epoch;
  logic [BOUND_W-1:0]        failure_boundary;
  logic signed [CODE_W-1:0]  failure_code;
  logic                      succeeded;
  logic [NOW_W-1:0]          now_ms;
  logic [SEL_W-1:0]          counter_select;

  modport source (
    output valid, kind, observed_epoch, failure_boundary, failure_code,
           succeeded, now_ms, counter_select,
    input  ready
  );
  modport sink (
    input  valid, kind, observed_epoch, failure_boundary, failure_code,
           succeeded, now_ms, counter_select,
    output ready
  );
endinterface

interface dlrs_out_if
  import dlrs_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [MODE_W-1:0]         device_state;
  logic [EPOCH_W-1:0]        epoch_now;
  logic                      submission_allowed;
  logic [BOUND_W-1:0]        last_boundary;
  logic signed [CODE_W-1:0]  last_code;
  logic [CNT_OUT_W-1:0]      counter_value;

  modport source (
    output valid, status, device_state, epoch_now, submission_allowed,
           last_boundary, last_code, counter_value,
    input  ready
  );
  modport sink (
    input  valid, status, device_state, epoch_now, submission_allowed,
           last_boundary, last_code, counter_value,
    output ready
  );
endinterface

interface dlrs_cfg_if
  import dlrs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/dlrs_counters.sv
// Bank of nine wrapping event counters with a selected read of the updated values.
`default_nettype none

module dlrs_counters
  import dlrs_pkg::*;
#(
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bump_t                bump,
  input  wire logic [SEL_W-1:0]     sel,
  output logic      [CNT_OUT_W-1:0] value
);

  logic [COUNTER_WIDTH-1:0] counts_r   [NUM_COUNTERS];
  logic [COUNTER_WIDTH-1:0] counts_nxt [NUM_COUNTERS];

  // Each counter bumps itself when addressed
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (bump.en && (bump.idx == cnt_sel_t'(SEL_W'(i)))) begin
        counts_nxt[i] = counts_r[i] + 1'b1;
      end else begin
        counts_nxt[i] = counts_r[i];
      end
    end
  end

  // Report the value as it stands after this event; unused selects read zero
  always_comb begin
    if (sel < SEL_W'(NUM_COUNTERS)) begin
      value = CNT_OUT_W'(counts_nxt[sel]);
    end else begin
      value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/dlrs_core.sv
// Recovery sequencer: mode, epoch, backoff and deadline state with its update logic.
`default_nettype none

module dlrs_core
  import dlrs_pkg::*;
#(
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire item_t   item,
  input  wire cfg_wr_t cfg,
  output result_t      res
);

  // Configuration registers
  logic [EPOCH_W-1:0]   init_epoch_r;
  logic [BACKOFF_W-1:0] init_backoff_r, max_backoff_r;
  logic [EPOCH_W-1:0]   init_epoch_nxt;
  logic [BACKOFF_W-1:0] init_backoff_nxt, max_backoff_nxt;

  // Sequencer state
  mode_t                 mode_r, mode_nxt;
  mode_t                 ret_mode_r, ret_mode_nxt;
  logic [EPOCH_W-1:0]    epoch_r, epoch_nxt;
  logic [BACKOFF_W-1:0]  backoff_r, backoff_nxt;
  logic [TIME_WIDTH-1:0] deadline_r, deadline_nxt;
  logic [BOUND_W-1:0]    bound_r, bound_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;

  status_t               status;
  bump_t                 bump;
  logic                  sched;
  logic                  recov;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH:0]   dl_sum;
  logic [TIME_WIDTH-1:0] dl_sched;
  logic [BACKOFF_W:0]    bo_dbl;
  logic [BACKOFF_W-1:0]  bo_sched;
  logic [CNT_OUT_W-1:0]  cnt_value;

  assign now = TIME_WIDTH'(item.now_ms);

  // Next probe deadline, saturating at the top of the time range
  assign dl_sum   = (TIME_WIDTH+1)'(now) + (TIME_WIDTH+1)'(backoff_r);
  assign dl_sched = dl_sum[TIME_WIDTH] ? '1 : dl_sum[TIME_WIDTH-1:0];

  // Doubled backoff, clamped to the maximum
  assign bo_dbl   = {backoff_r, 1'b0};
  assign bo_sched = (bo_dbl > {1'b0, max_backoff_r}) ? max_backoff_r : bo_dbl[BACKOFF_W-1:0];

  // Event decode and next state
  always_comb begin
    mode_nxt         = mode_r;
    ret_mode_nxt     = ret_mode_r;
    epoch_nxt        = epoch_r;
    backoff_nxt      = backoff_r;
    deadline_nxt     = deadline_r;
    bound_nxt        = bound_r;
    code_nxt         = code_r;
    init_epoch_nxt   = init_epoch_r;
    init_backoff_nxt = init_backoff_r;
    max_backoff_nxt  = max_backoff_r;
    status           = ST_INVALID;
    bump             = '{en: 1'b0, idx: CNT_LOSS};
    sched            = 1'b0;
    recov            = 1'b0;

    if (step) begin
      if (item.kind > KIND_QUERY) begin
        status = ST_INVALID;
      end else if (mode_r == M_CLOSED) begin
        status = ST_CLOSED;
      end else begin
        unique case (item.kind)
          KIND_LOSS: begin
            if (item.observed_epoch != epoch_r) begin
              bump   = '{en: 1'b1, idx: CNT_STALE};
              status = ST_STALE;
            end else if (mode_r != M_HW && mode_r != M_FBREADY) begin
              bump = '{en: 1'b1, idx: CNT_DUP_LOSS};
            end else if (epoch_r != EPOCH_MAX) begin
              epoch_nxt = epoch_r + 1'b1;
              bound_nxt = item.failure_boundary;
              code_nxt  = item.failure_code;
              mode_nxt  = M_LOSS;
              bump      = '{en: 1'b1, idx: CNT_LOSS};
              status    = ST_OK;
            end
          end
          KIND_QUIESCE: begin
            if (mode_r == M_LOSS) begin
              mode_nxt = M_QUIESCE;
              status   = ST_OK;
            end
          end
          KIND_RECREATE_START: begin
            if (mode_r == M_QUIESCE) begin
              mode_nxt = M_RECREATE;
              bump     = '{en: 1'b1, idx: CNT_HW_TRY};
              status   = ST_OK;
            end
          end
          KIND_RECREATE_DONE: begin
            if (mode_r == M_RECREATE) begin
              if (item.succeeded) begin
                recov = 1'b1;
              end else begin
                mode_nxt = M_FBCREATE;
                bump     = '{en: 1'b1, idx: CNT_FB_TRY};
              end
              status = ST_OK;
            end
          end
          KIND_FALLBACK_DONE: begin
            if (mode_r == M_FBCREATE) begin
              if (item.succeeded) begin
                mode_nxt = M_FBREADY;
                bump     = '{en: 1'b1, idx: CNT_FB_OK};
              end else begin
                mode_nxt = M_SW;
                bump     = '{en: 1'b1, idx: CNT_SW};
              end
              sched  = 1'b1;
              status = ST_OK;
            end
          end
          KIND_PROBE_START: begin
            if ((mode_r == M_FBREADY || mode_r == M_SW) && now >= deadline_r &&
                epoch_r != EPOCH_MAX) begin
              ret_mode_nxt = mode_r;
              epoch_nxt    = epoch_r + 1'b1;
              mode_nxt     = M_PROBE;
              bump         = '{en: 1'b1, idx: CNT_PROBE_TRY};
              status       = ST_OK;
            end
          end
          KIND_PROBE_DONE: begin
            if (mode_r == M_PROBE) begin
              if (item.succeeded) begin
                recov = 1'b1;
              end else begin
                mode_nxt = ret_mode_r;
                sched    = 1'b1;
              end
              status = ST_OK;
            end
          end
          KIND_CLOSE: begin
            mode_nxt = M_CLOSED;
            status   = ST_OK;
          end
          KIND_QUERY: begin
            status = ST_OK;
          end
          default: begin
            status = ST_INVALID;
          end
        endcase
      end
    end

    // Probe scheduling after a fallback outcome or a failed probe
    if (sched) begin
      deadline_nxt = dl_sched;
      backoff_nxt  = bo_sched;
    end

    // Back on hardware: restart the backoff sequence
    if (recov) begin
      mode_nxt     = M_HW;
      backoff_nxt  = init_backoff_r;
      deadline_nxt = '0;
      bump         = '{en: 1'b1, idx: CNT_HW_OK};
    end

    // Register writes, which also load the live epoch and backoff
    if (cfg.en) begin
      unique case (cfg.idx)
        CFG_INITIAL_EPOCH: begin
          init_epoch_nxt = cfg.data[EPOCH_W-1:0];
          epoch_nxt      = (cfg.data[EPOCH_W-1:0] == '0) ? EPOCH_W'(1) : cfg.data[EPOCH_W-1:0];
        end
        CFG_INITIAL_BACKOFF: begin
          init_backoff_nxt = cfg.data[BACKOFF_W-1:0];
          backoff_nxt      = cfg.data[BACKOFF_W-1:0];
        end
        CFG_MAX_BACKOFF: begin
          max_backoff_nxt = cfg.data[BACKOFF_W-1:0];
        end
        default: begin
          max_backoff_nxt = max_backoff_r;
        end
      endcase
    end
  end

  dlrs_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk   (clk),
    .rst_n (rst_n),
    .bump  (bump),
    .sel   (item.counter_select),
    .value (cnt_value)
  );

  // Result reflects the state after this event
  always_comb begin
    res.status             = status;
    res.device_state       = mode_nxt;
    res.epoch_now          = epoch_nxt;
    res.submission_allowed = (mode_nxt == M_HW) || (mode_nxt == M_FBREADY);
    res.last_boundary      = bound_nxt;
    res.last_code          = code_nxt;
    res.counter_value      = cnt_value;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= M_HW;
      ret_mode_r     <= M_SW;
      epoch_r        <= RST_INITIAL_EPOCH;
      backoff_r      <= RST_INITIAL_BACKOFF;
      deadline_r     <= '0;
      bound_r        <= '0;
      code_r         <= '0;
      init_epoch_r   <= RST_INITIAL_EPOCH;
      init_backoff_r <= RST_INITIAL_BACKOFF;
      max_backoff_r  <= RST_MAX_BACKOFF;
    end else begin
      mode_r         <= mode_nxt;
      ret_mode_r     <= ret_mode_nxt;
      epoch_r        <= epoch_nxt;
      backoff_r      <= backoff_nxt;
      deadline_r     <= deadline_nxt;
      bound_r        <= bound_nxt;
      code_r         <= code_nxt;
      init_epoch_r   <= init_epoch_nxt;
      init_backoff_r <= init_backoff_nxt;
      max_backoff_r  <= max_backoff_nxt;
    end
  end

  // Closed is terminal until reset
  a_closed_sticky: assert property (@(posedge clk)
    rst_n && mode_r == M_CLOSED |=> mode_r == M_CLOSED)
    else $error("sequencer left the closed state");

  // Epoch only moves forward outside register writes
  a_epoch_monotonic: assert property (@(posedge clk)
    rst_n && !cfg.en |=> epoch_r >= $past(epoch_r))
    else $error("epoch went backwards");

  // A stale loss report changes neither epoch nor mode
  a_stale_no_change: assert property (@(posedge clk)
    rst_n && !cfg.en && step && item.kind == KIND_LOSS && mode_r != M_CLOSED &&
    item.observed_epoch != epoch_r
    |=> epoch_r == $past(epoch_r) && mode_r == $past(mode_r))
    else $error("stale loss altered sequencer state");

endmodule

`default_nettype wire

>>> src/device_loss_recovery_sequencer_top.sv
// Top level of the device loss recovery sequencer: input register, sequencer, result register.
//
//  channel  | dir | transfer when         | carries
//  ---------+-----+-----------------------+-----------------------------------------
//  cfg_ch   | in  | valid && ready        | register index, write data
//  in_ch    | in  | valid && ready        | one recovery event
//  out_ch   | out | valid && ready        | one result per event
//
// One event per cycle sustained while results are taken; an event passes through the input
// register and then the result register before its result is offered.
// The single sequencer stage updates all state in the cycle the event leaves the
// input register, so consecutive events see each other's effects.
// Reset is synchronous and active low; all state is ready on the first cycle after it.
// A stalled result holds in the result register; the input register still takes one
// more event, then ready drops until the result is taken.
`default_nettype none

module device_loss_recovery_sequencer_top
  import dlrs_pkg::*;
#(
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH,
  parameter int TIME_WIDTH    = DEF_TIME_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dlrs_cfg_if.sink    cfg_ch,
  dlrs_in_if.sink     in_ch,
  dlrs_out_if.source  out_ch
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  cfg_wr_t cfg;
  logic    in_acc;
  logic    adv;

  // Handshake control
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cfg = '{en: cfg_ch.valid && cfg_ch.ready, idx: cfg_ch.index, data: cfg_ch.data};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{kind:             in_ch.kind,
                     observed_epoch:   in_ch.observed_epoch,
                     failure_boundary: in_ch.failure_boundary,
                     failure_code:     in_ch.failure_code,
                     succeeded:        in_ch.succeeded,
                     now_ms:           in_ch.now_ms,
                     counter_select:   in_ch.counter_select};
    end
  end

  dlrs_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_res_r.status;
  assign out_ch.device_state       = out_res_r.device_state;
  assign out_ch.epoch_now          = out_res_r.epoch_now;
  assign out_ch.submission_allowed = out_res_r.submission_allowed;
  assign out_ch.last_boundary      = out_res_r.last_boundary;
  assign out_ch.last_code          = out_res_r.last_code;
  assign out_ch.counter_value      = out_res_r.counter_value;

  // No result is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  // Both stages full and output stalled: no further transfer in
  a_full_backpressure: assert property (@(posedge clk)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted with pipeline full");

  // An accepted event always lands in the input register
  a_accept_lands: assert property (@(posedge clk)
    rst_n && in_acc |=> s1_valid_r)
    else $error("accepted event lost");

endmodule

`default_nettype wire
